// ===== rtl/dsbm_pkg.sv =====
`timescale 1ns / 1ps

package dsbm_pkg;

    // action codes carried in the input word
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_EXEC  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // instruction opcodes
    localparam logic [7:0] OP_NOP = 8'd0;
    localparam logic [7:0] OP_LIT = 8'd1;
    localparam logic [7:0] OP_GTH = 8'd2;
    localparam logic [7:0] OP_JMP = 8'd3;
    localparam logic [7:0] OP_TOR = 8'd4;
    localparam logic [7:0] OP_FRR = 8'd5;
    localparam logic [7:0] OP_JCN = 8'd6;
    localparam logic [7:0] OP_DRP = 8'd7;
    localparam logic [7:0] OP_NIP = 8'd8;
    localparam logic [7:0] OP_SWP = 8'd9;
    localparam logic [7:0] OP_ROT = 8'd10;
    localparam logic [7:0] OP_DUP = 8'd11;
    localparam logic [7:0] OP_OVR = 8'd12;
    localparam logic [7:0] OP_ADD = 8'd13;
    localparam logic [7:0] OP_SUB = 8'd14;
    localparam logic [7:0] OP_MUL = 8'd15;
    localparam logic [7:0] OP_DIV = 8'd16;

    // fault codes
    localparam logic [2:0] FLT_NONE   = 3'd0;
    localparam logic [2:0] FLT_DUF    = 3'd1;
    localparam logic [2:0] FLT_DOF    = 3'd2;
    localparam logic [2:0] FLT_RUF    = 3'd3;
    localparam logic [2:0] FLT_ROF    = 3'd4;
    localparam logic [2:0] FLT_BAD_OP = 3'd5;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    // request from the sequencer to the shared arithmetic unit
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    // which operand a push takes
    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_C,
        SEL_R
    } push_sel_t;

    // micro-op: pops into a, b, c in order, optional alu step, then pushes
    typedef struct packed {
        logic      valid;
        logic [1:0] npop;
        logic      pop_ret;
        logic [1:0] npush;
        logic      push_ret;
        push_sel_t sel0;
        push_sel_t sel1;
        push_sel_t sel2;
        logic      use_alu;
        alu_op_t   alu_op;
        logic      is_lit;
        logic      is_jmp;
        logic      is_jcn;
    } uop_t;

    function automatic uop_t dsbm_decode(input logic [7:0] op);
        uop_t u;
        u = '0;
        u.valid = 1'b1;
        unique case (op) inside
            OP_NOP: u.valid = 1'b1;
            OP_LIT:
            begin
                u.is_lit = 1'b1;
                u.npush  = 2'd1;
                u.sel0   = SEL_A;
            end
            OP_GTH:
            begin
                u.npush = 2'd1;
                u.sel0  = SEL_R;
            end
            OP_JMP:
            begin
                u.npop   = 2'd1;
                u.is_jmp = 1'b1;
            end
            OP_TOR:
            begin
                u.npop     = 2'd1;
                u.npush    = 2'd1;
                u.push_ret = 1'b1;
                u.sel0     = SEL_A;
            end
            OP_FRR:
            begin
                u.npop    = 2'd1;
                u.pop_ret = 1'b1;
                u.npush   = 2'd1;
                u.sel0    = SEL_A;
            end
            OP_JCN:
            begin
                u.npop   = 2'd2;
                u.is_jcn = 1'b1;
            end
            OP_DRP: u.npop = 2'd1;
            OP_NIP:
            begin
                u.npop  = 2'd2;
                u.npush = 2'd1;
                u.sel0  = SEL_A;
            end
            OP_SWP:
            begin
                u.npop  = 2'd2;
                u.npush = 2'd2;
                u.sel0  = SEL_A;
                u.sel1  = SEL_B;
            end
            OP_ROT:
            begin
                u.npop  = 2'd3;
                u.npush = 2'd3;
                u.sel0  = SEL_B;
                u.sel1  = SEL_A;
                u.sel2  = SEL_C;
            end
            OP_DUP:
            begin
                u.npop  = 2'd1;
                u.npush = 2'd2;
                u.sel0  = SEL_A;
                u.sel1  = SEL_A;
            end
            OP_OVR:
            begin
                u.npop  = 2'd2;
                u.npush = 2'd3;
                u.sel0  = SEL_B;
                u.sel1  = SEL_A;
                u.sel2  = SEL_B;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                u.npop    = 2'd2;
                u.npush   = 2'd1;
                u.sel0    = SEL_R;
                u.use_alu = 1'b1;
                u.alu_op  = (op == OP_ADD) ? ALU_ADD :
                            (op == OP_SUB) ? ALU_SUB :
                            (op == OP_MUL) ? ALU_MUL : ALU_DIV;
            end
            default: u.valid = 1'b0;
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/dsbm_alu.sv =====
`timescale 1ns / 1ps

module dsbm_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  dsbm_pkg::alu_req_t req,
    input  logic [7:0]         lhs,
    input  logic [7:0]         rhs,
    output logic               done,
    output logic [7:0]         result
);
    import dsbm_pkg::*;

    logic       busy_reg;
    logic       done_reg;
    logic [2:0] cnt_reg;
    logic [7:0] rem_reg;
    logic [7:0] quo_reg;
    logic [7:0] dvs_reg;
    logic [7:0] result_reg;
    logic [8:0] rem_sh;
    logic [9:0] diff;
    logic       q_bit;
    logic [15:0] prod;

    // one restoring divide step: shift in the next dividend bit, trial subtract
    assign rem_sh = {rem_reg, quo_reg[7]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign q_bit  = ~diff[9];
    assign prod   = lhs * rhs;

    // control: add, sub, mul and divide by zero finish at once, a real divide runs eight steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.op == ALU_DIV && rhs != 8'd0)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 3'd0;
                end
                else
                begin
                    done_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= 8'd0;
            quo_reg <= lhs;
            dvs_reg <= rhs;
            unique case (req.op)
                ALU_ADD: result_reg <= lhs + rhs;
                ALU_SUB: result_reg <= lhs - rhs;
                ALU_MUL: result_reg <= prod[7:0];
                default: result_reg <= 8'd0;
            endcase
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? diff[7:0] : rem_sh[7:0];
            quo_reg <= {quo_reg[6:0], q_bit};
            if (cnt_reg == 3'd7)
            begin
                result_reg <= {quo_reg[6:0], q_bit};
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/dual_stack_byte_machine.sv =====
`timescale 1ns / 1ps

// Byte-wide two-stack machine. Each input word carries an action: write one
// program byte, execute the instruction at the program counter, or clear the
// counter and both stack pointers; every action returns exactly one status
// word (counter, top of data stack, both depths, halted, fault). Items are
// handled one at a time by a small sequencer around one synchronous program
// memory, two stack memories and a shared arithmetic unit. A write, clear or
// unused action passes idle and both status states; an execute that meets
// the halt opcode also passes decode. Any other execute takes the word and
// fetches the opcode, decodes, fetches the literal of lit, spends a read step
// and a wait step per stack pop (only the first when that stack is empty),
// leaves the pop phase, waits on the shared unit for add, sub, mul and div,
// pushes each value, updates the counter and reads back the status through
// S_TOP and S_TOPW. A status word not yet taken holds the sequencer in its
// last state. The next word is taken as soon as the status word sits in the
// output register. halt_opcode is register 0 on the configuration port.
module dual_stack_byte_machine #(
    parameter int STACK_DEPTH = 16,
    parameter int MEM_DEPTH   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[1:0], address[9:2], data[17:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // program_counter[7:0], top_of_data[15:8],
                                   // data_depth[20:16], return_depth[25:21],
                                   // halted[26], fault[29:27]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dsbm_pkg::*;

    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int MA_W = $clog2(MEM_DEPTH);
    localparam logic [SP_W-1:0] STK_FULL = SP_W'(STACK_DEPTH);
    localparam logic [2:0] ADDR_HALT = 3'd0;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_LIT    = 4'd2;
    localparam logic [3:0] S_POP    = 4'd3;
    localparam logic [3:0] S_POPW   = 4'd4;
    localparam logic [3:0] S_ALU    = 4'd5;
    localparam logic [3:0] S_PUSH   = 4'd6;
    localparam logic [3:0] S_TOP    = 4'd7;
    localparam logic [3:0] S_TOPW   = 4'd8;

    // control state
    logic [3:0]      state_reg, state_next;
    logic [7:0]      pc_reg, pc_next;
    logic [SP_W-1:0] dp_reg, dp_next;
    logic [SP_W-1:0] rp_reg, rp_next;
    logic [1:0]      slot_reg, slot_next;
    logic [1:0]      pidx_reg, pidx_next;
    logic [2:0]      fault_reg, fault_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      halt_reg;

    // payload
    uop_t            uop_reg, uop_next;
    logic [7:0]      opa_reg, opa_next;
    logic [7:0]      opb_reg, opb_next;
    logic [7:0]      opc_reg, opc_next;
    logic [7:0]      res_reg, res_next;
    logic [31:0]     out_word_reg, out_word_next;

    // memories
    logic [7:0]      prog_mem [MEM_DEPTH];
    logic [7:0]      dstk_mem [STACK_DEPTH];
    logic [7:0]      rstk_mem [STACK_DEPTH];
    logic [7:0]      mem_q_reg, dstk_q_reg, rstk_q_reg;
    logic            mem_re, mem_we;
    logic [MA_W-1:0] mem_raddr, mem_waddr;
    logic [7:0]      mem_wdata;
    logic            dstk_re, dstk_we, rstk_re, rstk_we;
    logic [7:0]      stk_wdata;
    logic [SA_W-1:0] dstk_raddr, dstk_waddr, rstk_raddr, rstk_waddr;

    // address reduction table for program memory
    logic [MA_W-1:0] mod_tab [256];

    // misc
    logic [1:0]      in_action;
    logic [7:0]      in_addr, in_data;
    logic            accept;
    logic [7:0]      pc_inc;
    logic [SP_W-1:0] pop_ptr, push_ptr;
    push_sel_t       sel_cur;
    logic [7:0]      push_val;
    logic [7:0]      pop_val;
    logic [7:0]      top_val;
    logic            halted;
    uop_t            dec_uop;
    alu_req_t        alu_req;
    logic            alu_done;
    logic [7:0]      alu_result;

    for (genvar g = 0; g < 256; g++)
    begin : g_mod
        assign mod_tab[g] = MA_W'(g % MEM_DEPTH);
    end

    assign in_action = s_tdata[1:0];
    assign in_addr   = s_tdata[9:2];
    assign in_data   = s_tdata[17:10];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign pc_inc    = pc_reg + 8'd1;

    assign pop_ptr  = uop_reg.pop_ret ? rp_reg : dp_reg;
    assign push_ptr = uop_reg.push_ret ? rp_reg : dp_reg;
    assign pop_val  = uop_reg.pop_ret ? rstk_q_reg : dstk_q_reg;
    assign dec_uop  = dsbm_decode(mem_q_reg);

    // stack addresses: reads at pointer minus one, writes at the pointer
    assign dstk_raddr = SA_W'(dp_reg - SP_W'(1));
    assign rstk_raddr = SA_W'(rp_reg - SP_W'(1));
    assign dstk_waddr = SA_W'(dp_reg);
    assign rstk_waddr = SA_W'(rp_reg);

    // push value select
    always_comb
    begin
        sel_cur = (pidx_reg == 2'd0) ? uop_reg.sel0 :
                  (pidx_reg == 2'd1) ? uop_reg.sel1 : uop_reg.sel2;
        case (sel_cur)
            SEL_A:   push_val = opa_reg;
            SEL_B:   push_val = opb_reg;
            SEL_C:   push_val = opc_reg;
            default: push_val = res_reg;
        endcase
    end

    assign stk_wdata = push_val;
    assign top_val   = (dp_reg != '0) ? dstk_q_reg : 8'd0;
    assign halted    = (mem_q_reg == halt_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        dp_next        = dp_reg;
        rp_next        = rp_reg;
        slot_next      = slot_reg;
        pidx_next      = pidx_reg;
        fault_next     = fault_reg;
        uop_next       = uop_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        opc_next       = opc_reg;
        res_next       = res_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_re         = 1'b0;
        mem_raddr      = mod_tab[pc_reg];
        mem_we         = 1'b0;
        mem_waddr      = mod_tab[in_addr];
        mem_wdata      = in_data;
        dstk_re        = 1'b0;
        dstk_we        = 1'b0;
        rstk_re        = 1'b0;
        rstk_we        = 1'b0;
        alu_req.start  = 1'b0;
        alu_req.op     = uop_reg.alu_op;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fault_next = FLT_NONE;
                    state_next = S_TOP;
                    case (in_action)
                        ACT_WRITE: mem_we = 1'b1;
                        ACT_EXEC:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_DECODE;
                        end
                        ACT_CLEAR:
                        begin
                            pc_next = 8'd0;
                            dp_next = '0;
                            rp_next = '0;
                        end
                        default: state_next = S_TOP;
                    endcase
                end
            end
            S_DECODE:
            begin
                if (halted)
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    uop_next  = dec_uop;
                    slot_next = 2'd0;
                    pidx_next = 2'd0;
                    res_next  = pc_reg;
                    if (!dec_uop.valid)
                    begin
                        fault_next = FLT_BAD_OP;
                    end
                    if (dec_uop.is_lit)
                    begin
                        pc_next    = pc_inc;
                        mem_re     = 1'b1;
                        mem_raddr  = mod_tab[pc_inc];
                        state_next = S_LIT;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_LIT:
            begin
                opa_next   = mem_q_reg;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (slot_reg == uop_reg.npop)
                begin
                    if (uop_reg.use_alu)
                    begin
                        alu_req.start = 1'b1;
                        state_next    = S_ALU;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else if (pop_ptr == '0)
                begin
                    // underflow pops a zero and leaves the pointer alone
                    if (fault_reg == FLT_NONE)
                    begin
                        fault_next = uop_reg.pop_ret ? FLT_RUF : FLT_DUF;
                    end
                    case (slot_reg)
                        2'd0:    opa_next = 8'd0;
                        2'd1:    opb_next = 8'd0;
                        default: opc_next = 8'd0;
                    endcase
                    slot_next = slot_reg + 2'd1;
                end
                else
                begin
                    if (uop_reg.pop_ret)
                    begin
                        rstk_re = 1'b1;
                        rp_next = rp_reg - SP_W'(1);
                    end
                    else
                    begin
                        dstk_re = 1'b1;
                        dp_next = dp_reg - SP_W'(1);
                    end
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                case (slot_reg)
                    2'd0:    opa_next = pop_val;
                    2'd1:    opb_next = pop_val;
                    default: opc_next = pop_val;
                endcase
                slot_next  = slot_reg + 2'd1;
                state_next = S_POP;
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    res_next   = alu_result;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (pidx_reg < uop_reg.npush)
                begin
                    // overflow drops the push
                    if (push_ptr >= STK_FULL)
                    begin
                        if (fault_reg == FLT_NONE)
                        begin
                            fault_next = uop_reg.push_ret ? FLT_ROF : FLT_DOF;
                        end
                    end
                    else if (uop_reg.push_ret)
                    begin
                        rstk_we = 1'b1;
                        rp_next = rp_reg + SP_W'(1);
                    end
                    else
                    begin
                        dstk_we = 1'b1;
                        dp_next = dp_reg + SP_W'(1);
                    end
                    pidx_next = pidx_reg + 2'd1;
                end
                else
                begin
                    // counter advance, after any jump target is taken
                    if (uop_reg.is_jmp)
                    begin
                        pc_next = opa_reg + 8'd1;
                    end
                    else if (uop_reg.is_jcn && opa_reg != 8'd0)
                    begin
                        pc_next = opb_reg + 8'd1;
                    end
                    else
                    begin
                        pc_next = pc_inc;
                    end
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                dstk_re    = 1'b1;
                mem_re     = 1'b1;
                state_next = S_TOPW;
            end
            S_TOPW:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_word_next  = {2'b00, fault_reg, halted, 5'(rp_reg),
                                      5'(dp_reg), top_val, pc_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 8'd0;
            dp_reg        <= '0;
            rp_reg        <= '0;
            slot_reg      <= 2'd0;
            pidx_reg      <= 2'd0;
            fault_reg     <= FLT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            dp_reg        <= dp_next;
            rp_reg        <= rp_next;
            slot_reg      <= slot_next;
            pidx_reg      <= pidx_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        uop_reg      <= uop_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        opc_reg      <= opc_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    // program memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prog_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= prog_mem[mem_raddr];
        end
    end

    // data stack memory
    always_ff @(posedge clk)
    begin
        if (dstk_we)
        begin
            dstk_mem[dstk_waddr] <= stk_wdata;
        end
        if (dstk_re)
        begin
            dstk_q_reg <= dstk_mem[dstk_raddr];
        end
    end

    // return stack memory
    always_ff @(posedge clk)
    begin
        if (rstk_we)
        begin
            rstk_mem[rstk_waddr] <= stk_wdata;
        end
        if (rstk_re)
        begin
            rstk_q_reg <= rstk_mem[rstk_raddr];
        end
    end

    // shared arithmetic unit
    dsbm_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .lhs    (opb_reg),
        .rhs    (opa_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_reg <= 8'hFF;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_HALT)
        begin
            halt_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr == ADDR_HALT) ? {24'd0, halt_reg} : 32'd0;
    assign pready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;

    // checks
    a_dp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dp_reg <= STK_FULL)
        else $error("data stack pointer beyond depth");

    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= STK_FULL)
        else $error("return stack pointer beyond depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted while sequencer still took input");

    a_alu_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> state_reg == S_ALU)
        else $error("arithmetic result arrived outside the alu wait");

endmodule

// ===== test/tb_dual_stack_byte_machine.sv =====
`timescale 1ns / 1ps

module tb_dual_stack_byte_machine;
    import dsbm_pkg::*;

    localparam int         STACK_DEPTH   = 16;
    localparam int         MEM_DEPTH     = 256;
    localparam logic [1:0] ACT_NONE      = 2'd3;    // unused action code
    localparam logic [2:0] REG_HALT_ADDR = 3'd0;    // halt_opcode register
    localparam logic [7:0] OP_UNKNOWN    = 8'd200;
    localparam int         PHASE_WORDS   = 140;
    localparam int         CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [7:0] pc;
        logic [7:0] top;
        logic [4:0] ddepth;
        logic [4:0] rdepth;
        logic       halted;
        logic [2:0] fault;
    } machine_status_t;

    typedef struct {
        logic [1:0]      action;
        logic [7:0]      address;
        logic [7:0]      data;
        bit              typed;
        machine_status_t want;
    } probe_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // action[1:0], address[9:2], data[17:10]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [31:0] m_tdata;          // program_counter[7:0], top_of_data[15:8],
                                   // data_depth[20:16], return_depth[25:21],
                                   // halted[26], fault[29:27]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // machine state as the testbench sees it
    logic [7:0]      prog_mem [MEM_DEPTH];
    logic [7:0]      pc_q;
    logic [7:0]      dstk [STACK_DEPTH];
    int unsigned     dptr;
    logic [7:0]      rstk [STACK_DEPTH];
    int unsigned     rptr;
    logic [7:0]      halt_code;
    logic [2:0]      step_fault;
    machine_status_t last_status;

    machine_status_t status_due [$];
    probe_row_t      probe_rows [$];
    int              mismatch_count = 0;
    int              words_sent     = 0;
    int              cycle_count    = 0;
    int              hold_left      = 0;
    bit              calm           = 1'b0;

    dual_stack_byte_machine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // opcode-heavy random program byte
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'($urandom_range(0, 16));
        else if (r < 70)
            return halt_code;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // stack access, first fault of a step wins
    function automatic void raise_fault(input logic [2:0] code);
        if (step_fault == FLT_NONE)
            step_fault = code;
    endfunction

    function automatic void push_data(input logic [7:0] v);
        if (dptr >= STACK_DEPTH)
            raise_fault(FLT_DOF);
        else
        begin
            dstk[dptr] = v;
            dptr++;
        end
    endfunction

    function automatic logic [7:0] pop_data();
        if (dptr == 0)
        begin
            raise_fault(FLT_DUF);
            return 8'd0;
        end
        dptr--;
        return dstk[dptr];
    endfunction

    function automatic void push_ret(input logic [7:0] v);
        if (rptr >= STACK_DEPTH)
            raise_fault(FLT_ROF);
        else
        begin
            rstk[rptr] = v;
            rptr++;
        end
    endfunction

    function automatic logic [7:0] pop_ret();
        if (rptr == 0)
        begin
            raise_fault(FLT_RUF);
            return 8'd0;
        end
        rptr--;
        return rstk[rptr];
    endfunction

    // status word the machine should return for one input word
    function automatic machine_status_t machine_step(input logic [1:0] action,
                                                     input logic [7:0] address,
                                                     input logic [7:0] data);
        machine_status_t st;
        logic [7:0]      op;
        logic [7:0]      a;
        logic [7:0]      b;
        logic [7:0]      c;
        step_fault = FLT_NONE;
        case (action)
            ACT_WRITE: prog_mem[address] = data;
            ACT_CLEAR:
            begin
                pc_q = 8'd0;
                dptr = 0;
                rptr = 0;
            end
            ACT_EXEC:
            begin
                op = prog_mem[pc_q];
                // halt is checked before decode and holds the counter
                if (op != halt_code)
                begin
                    case (op) inside
                        OP_NOP: ;
                        OP_LIT:
                        begin
                            pc_q = pc_q + 8'd1;
                            push_data(prog_mem[pc_q]);
                        end
                        OP_GTH: push_data(pc_q);
                        OP_JMP: pc_q = pop_data();
                        OP_TOR: push_ret(pop_data());
                        OP_FRR: push_data(pop_ret());
                        OP_JCN:
                        begin
                            a = pop_data();
                            b = pop_data();
                            if (a != 8'd0)
                                pc_q = b;
                        end
                        OP_DRP: a = pop_data();
                        OP_NIP:
                        begin
                            a = pop_data();
                            b = pop_data();
                            push_data(a);
                        end
                        OP_SWP:
                        begin
                            a = pop_data();
                            b = pop_data();
                            push_data(a);
                            push_data(b);
                        end
                        OP_ROT:
                        begin
                            a = pop_data();
                            b = pop_data();
                            c = pop_data();
                            push_data(b);
                            push_data(a);
                            push_data(c);
                        end
                        OP_DUP:
                        begin
                            a = pop_data();
                            push_data(a);
                            push_data(a);
                        end
                        OP_OVR:
                        begin
                            a = pop_data();
                            b = pop_data();
                            push_data(b);
                            push_data(a);
                            push_data(b);
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        begin
                            a = pop_data();
                            b = pop_data();
                            if (op == OP_ADD)
                                c = b + a;
                            else if (op == OP_SUB)
                                c = b - a;
                            else if (op == OP_MUL)
                                c = b * a;
                            else
                                c = (a == 8'd0) ? 8'd0 : b / a;
                            push_data(c);
                        end
                        default: raise_fault(FLT_BAD_OP);
                    endcase
                    pc_q = pc_q + 8'd1;
                end
            end
            default: ;
        endcase
        st.pc     = pc_q;
        st.top    = (dptr > 0) ? dstk[dptr - 1] : 8'd0;
        st.ddepth = 5'(dptr);
        st.rdepth = 5'(rptr);
        st.halted = (prog_mem[pc_q] == halt_code);
        st.fault  = step_fault;
        return st;
    endfunction

    // result side: random stall bursts unless in a calm stretch
    always @(negedge clk)
    begin
        if (!rst_n || calm)
            m_tready <= 1'b1;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready  <= 1'b1;
            hold_left <= idle_len(75);
        end
    end

    // compare each status word against the oldest expected one
    always @(posedge clk)
    begin : check_word
        machine_status_t got;
        machine_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pc     = m_tdata[7:0];
            got.top    = m_tdata[15:8];
            got.ddepth = m_tdata[20:16];
            got.rdepth = m_tdata[25:21];
            got.halted = m_tdata[26];
            got.fault  = m_tdata[29:27];
            if (status_due.size() == 0)
                report_mismatch($sformatf("status word with nothing expected: %h", m_tdata));
            else
            begin
                want = status_due.pop_front();
                if (got.pc !== want.pc || got.top !== want.top
                    || got.ddepth !== want.ddepth || got.rdepth !== want.rdepth
                    || got.halted !== want.halted || got.fault !== want.fault)
                    report_mismatch($sformatf(
                        "pc %h/%h top %h/%h dd %0d/%0d rd %0d/%0d halt %b/%b fault %0d/%0d",
                        want.pc, got.pc, want.top, got.top, want.ddepth, got.ddepth,
                        want.rdepth, got.rdepth, want.halted, got.halted,
                        want.fault, got.fault));
            end
        end
    end

    // one input word; valid stays up across back-to-back words
    task automatic send_word(input logic [1:0] action, input logic [7:0] address,
                             input logic [7:0] data, input bit typed = 1'b0,
                             input machine_status_t want = '0);
        int gap;
        machine_status_t st;
        gap = calm ? 0 : idle_len(55);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, data, address, action};
        do
            @(posedge clk);
        while (!s_tready);
        st = machine_step(action, address, data);
        last_status = st;
        status_due.push_back(typed ? want : st);
        if (action != ACT_NONE)
            words_sent++;
    endtask

    // drop valid and wait for every expected word
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    // register write, then read back
    task automatic program_halt_code(input logic [7:0] value);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_HALT_ADDR;
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        halt_code = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[7:0] !== value)
            report_mismatch($sformatf("halt_opcode read %h, wrote %h", rd[7:0], value));
    endtask

    // program at address 0, then usually clear, and step it until halt or step budget
    task automatic run_program(input bit storm);
        int n;
        int pos;
        int steps;
        int r;
        logic [7:0] op;
        n   = storm ? $urandom_range(16, 24) : $urandom_range(3, 14);
        pos = 0;
        while (pos < n)
        begin
            r = $urandom_range(0, 99);
            if (storm && r < 85)
            begin
                case ($urandom_range(0, 5))
                    0: op = OP_LIT;
                    1: op = OP_GTH;
                    2: op = OP_DUP;
                    3: op = OP_OVR;
                    4: op = OP_TOR;
                    default: op = OP_FRR;
                endcase
                r = $urandom_range(0, 99);
            end
            if (storm && op != OP_LIT && r < 85)
                ;
            else if (r < 20)
                op = OP_LIT;
            else if (r < 25)
                op = OP_GTH;
            else if (r < 30)
                op = OP_NOP;
            else if (r < 55)
                op = OP_ADD + 8'($urandom_range(0, 3));
            else if (r < 75)
            begin
                case ($urandom_range(0, 5))
                    0: op = OP_DRP;
                    1: op = OP_NIP;
                    2: op = OP_SWP;
                    3: op = OP_ROT;
                    4: op = OP_DUP;
                    default: op = OP_OVR;
                endcase
            end
            else if (r < 83)
                op = ($urandom_range(0, 1) == 0) ? OP_TOR : OP_FRR;
            else if (r < 90)
                op = OP_JCN;
            else if (r < 93)
                op = OP_JMP;
            else if (r < 97)
                op = halt_code;
            else
                op = 8'($urandom_range(17, 254));
            send_word(ACT_WRITE, 8'(pos), op);
            pos++;
            if (op == OP_LIT && pos < n)
            begin
                send_word(ACT_WRITE, 8'(pos), 8'($urandom_range(0, 255)));
                pos++;
            end
        end
        if ($urandom_range(0, 1) == 0)
            send_word(ACT_WRITE, 8'(n), halt_code);
        if ($urandom_range(0, 99) < 85)
            send_word(ACT_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        steps = storm ? 32 : n + $urandom_range(2, 10);
        for (int s = 0; s < steps; s++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_word(ACT_WRITE, 8'($urandom_range(0, 255)), rand_byte());
            send_word(ACT_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            if (last_status.halted)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_word(ACT_EXEC, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                break;
            end
        end
    endtask

    // unstructured words of every action
    task automatic run_noise();
        int r;
        logic [1:0] action;
        repeat ($urandom_range(5, 15))
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                action = ACT_WRITE;
            else if (r < 80)
                action = ACT_EXEC;
            else if (r < 90)
                action = ACT_CLEAR;
            else
                action = ACT_NONE;
            send_word(action, 8'($urandom_range(0, 255)),
                      (action == ACT_WRITE) ? rand_byte() : 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int r;
        logic [7:0] b;
        pc_q      = 8'd0;
        dptr      = 0;
        rptr      = 0;
        halt_code = 8'hFF;
        foreach (prog_mem[k])
            prog_mem[k] = 8'd0;

        // directed rows: program preloaded below runs from address 0
        probe_rows.push_back('{ACT_EXEC, 8'd0, 8'd0, 1'b1,
                               '{8'd1, 8'd0, 5'd1, 5'd0, 1'b0, FLT_DUF}});
        repeat (14)
            probe_rows.push_back('{ACT_EXEC, 8'd0, 8'd0, 1'b0, '0});
        probe_rows.push_back('{ACT_EXEC, 8'd0, 8'd0, 1'b1,
                               '{8'd18, 8'd0, 5'd2, 5'd0, 1'b0, FLT_RUF}});
        repeat (4)
            probe_rows.push_back('{ACT_EXEC, 8'd0, 8'd0, 1'b0, '0});
        probe_rows.push_back('{ACT_EXEC, 8'd0, 8'd0, 1'b1,
                               '{8'd94, 8'd0, 5'd0, 5'd0, 1'b0, FLT_BAD_OP}});
        // lit 254, jmp to 255, lit wrapping past the end of memory
        repeat (3)
            probe_rows.push_back('{ACT_EXEC, 8'd0, 8'd0, 1'b0, '0});
        probe_rows.push_back('{ACT_WRITE, 8'd1, 8'hFF, 1'b1,
                               '{8'd1, 8'd16, 5'd1, 5'd0, 1'b1, FLT_NONE}});
        probe_rows.push_back('{ACT_EXEC, 8'd0, 8'd0, 1'b1,
                               '{8'd1, 8'd16, 5'd1, 5'd0, 1'b1, FLT_NONE}});
        probe_rows.push_back('{ACT_CLEAR, 8'd0, 8'd0, 1'b1,
                               '{8'd0, 8'd0, 5'd0, 5'd0, 1'b0, FLT_NONE}});
        probe_rows.push_back('{ACT_NONE, 8'hFF, 8'hFF, 1'b1,
                               '{8'd0, 8'd0, 5'd0, 5'd0, 1'b0, FLT_NONE}});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        program_halt_code(8'hFF);

        // fill all of memory, address 0 first, directed program in place
        for (int k = 0; k < MEM_DEPTH; k++)
        begin
            case (k)
                0:   b = OP_DIV;
                1:   b = OP_LIT;
                2:   b = 8'hFF;
                3:   b = OP_GTH;
                4:   b = OP_DUP;
                5:   b = OP_MUL;
                6:   b = OP_ADD;
                7:   b = OP_LIT;
                8:   b = 8'd200;
                9:   b = OP_SUB;
                10:  b = OP_OVR;
                11:  b = OP_SWP;
                12:  b = OP_ROT;
                13:  b = OP_NIP;
                14:  b = OP_DRP;
                15:  b = OP_TOR;
                16:  b = OP_FRR;
                17:  b = OP_FRR;
                18:  b = OP_JCN;
                19:  b = OP_LIT;
                20:  b = 8'd92;
                21:  b = OP_LIT;
                22:  b = 8'd1;
                23:  b = OP_JCN;
                24:  b = OP_NOP;
                93:  b = OP_UNKNOWN;
                94:  b = OP_LIT;
                95:  b = 8'd254;
                96:  b = OP_JMP;
                255: b = OP_LIT;
                default: b = rand_byte();
            endcase
            send_word(ACT_WRITE, 8'(k), b);
        end

        foreach (probe_rows[i])
            send_word(probe_rows[i].action, probe_rows[i].address, probe_rows[i].data,
                      probe_rows[i].typed, probe_rows[i].want);

        // random phases, each under its own halt opcode
        for (int ph = 0; ph < 3; ph++)
        begin
            settle();
            case (ph)
                0: program_halt_code(8'd17);
                1: program_halt_code(8'($urandom_range(18, 254)));
                default: program_halt_code(8'hFF);
            endcase
            words_sent = 0;
            while (words_sent < PHASE_WORDS)
            begin
                calm = ($urandom_range(0, 6) == 0);
                r = $urandom_range(0, 99);
                if (r < 65)
                    run_program(1'b0);
                else if (r < 80)
                    run_program(1'b1);
                else
                    run_noise();
            end
        end

        settle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && status_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
